// ===== rtl/bnl_pkg.sv =====
// ----------------------------------------------------------------------------
// bnl_pkg: shared types and helpers for the binary neuron layer
// Item kinds, the token that travels down the neuron chain, the mask
// carried between cells and the xnor/popcount weight term.
// ----------------------------------------------------------------------------
package bnl_pkg;

   localparam int DEF_MAX_INPUT_BYTES = 32;
   localparam int DEF_NEURON_COUNT    = 8;

   // result queue, deep enough to cover the chain latency at full rate
   localparam int RSP_DEPTH = 16;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam int BYTE_COUNT_W = 6;
   localparam int ACTIVE_W     = 4;
   localparam int CSR_DATA_W   = 6;
   localparam int SUM_W        = 16;
   localparam int MASK_W       = 8;

   // item kinds
   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_THRESH = 2'd1;
   localparam logic [1:0] OP_DATA   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // register indexes
   localparam logic CSR_BYTE_COUNT = 1'b0;
   localparam logic CSR_ACTIVE     = 1'b1;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        nsel;
      logic [7:0]        plane_high;
      logic [7:0]        plane_middle;
      logic [7:0]        plane_low;
      logic signed [15:0] fire_level;
      logic [7:0]        data_byte;
      logic              last;
   } token_type;

   typedef struct packed {
      logic              valid;
      logic [MASK_W-1:0] bits;
   } mask_type;

   function automatic logic [3:0] bnl_popcount(input logic [7:0] v);
      logic [3:0] c;
      c = 4'd0;
      for (int k = 0; k < 8; k++) begin
         c = c + 4'(v[k]);
      end
      return c;
   endfunction

   // 4*(2*ph-8) + 2*(2*pm-8) + (2*pl-8) = 8*ph + 4*pm + 2*pl - 56
   function automatic logic signed [7:0] bnl_term(input logic [7:0] d,
                                                 input logic [7:0] wh,
                                                 input logic [7:0] wm,
                                                 input logic [7:0] wl);
      logic [3:0] ph;
      logic [3:0] pm;
      logic [3:0] pl;
      logic [7:0] pos_sum;
      ph = bnl_popcount(~(d ^ wh));
      pm = bnl_popcount(~(d ^ wm));
      pl = bnl_popcount(~(d ^ wl));
      pos_sum = {1'b0, ph, 3'b000} + {2'b00, pm, 2'b00} + {3'b000, pl, 1'b0};
      return $signed(pos_sum - 8'd56);
   endfunction

endpackage

// ===== rtl/binary_neuron_layer_xnor_popcount_unit.sv =====
// ----------------------------------------------------------------------------
// binary_neuron_layer_xnor_popcount_unit: binarized threshold neuron layer
// Up to eight neurons with 3-bit bit-plane weights, xnor/popcount scoring.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready) carries weight writes, threshold writes and
//    input data bytes; one item per cycle, back to back, while req_ready is high.
//  - every item walks down a chain of NEURON_COUNT cells, one cell per
//    cycle, so writes and data reach each neuron in transfer order.
//  - after the configured number of data bytes, one fired mask appears on
//    rsp (valid/ready) once the last byte has passed the chain of cells,
//    the three stages (a, b, c) of the last cell and the result queue.
//  - csr port writes byte count (index 0) and active neurons (index 1);
//    write it only while no inference is in flight.
//  - reset clears sums, the byte counter, the queue and sets the registers
//    to one byte and eight neurons; weights and thresholds must be loaded.
//  - a stalled rsp side fills a 16-entry result queue; req_ready drops
//    only when that many results are owed to the receiver.
// ----------------------------------------------------------------------------
module binary_neuron_layer_xnor_popcount_unit
   import bnl_pkg::*;
#(
   parameter int MAX_INPUT_BYTES = DEF_MAX_INPUT_BYTES,
   parameter int NEURON_COUNT    = DEF_NEURON_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [2:0]            req_neuron_sel,
   input  logic [4:0]            req_byte_pos,
   input  logic [7:0]            req_plane_high,
   input  logic [7:0]            req_plane_middle,
   input  logic [7:0]            req_plane_low,
   input  logic signed [15:0]    req_fire_level,
   input  logic [7:0]            req_data_byte,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [MASK_W-1:0]     rsp_fired_mask,

   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int ADDR_W  = (MAX_INPUT_BYTES > 1) ? $clog2(MAX_INPUT_BYTES) : 1;
   localparam int CNT_W   = ($clog2(MAX_INPUT_BYTES + 1) > BYTE_COUNT_W) ?
                            $clog2(MAX_INPUT_BYTES + 1) : BYTE_COUNT_W;
   localparam int POS_W   = (ADDR_W > 5) ? ADDR_W : 5;

   logic [BYTE_COUNT_W-1:0] byte_count_ff;
   logic [ACTIVE_W-1:0]     active_ff;
   logic [ADDR_W-1:0]       bytes_seen_ff;
   logic [RSP_CNT_W-1:0]    pending_ff;
   logic [RSP_CNT_W-1:0]    pending_in;

   logic                    req_xfer;
   logic                    rsp_xfer;
   logic [CNT_W-1:0]        count_clamp;
   logic [ACTIVE_W-1:0]     active_clamp;
   logic [CNT_W-1:0]        seen_next;
   logic                    is_last;
   logic                    last_xfer;
   logic                    sel_ok;
   logic                    pos_ok;
   logic [POS_W-1:0]        pos_wide;

   token_type               tok_chain  [NEURON_COUNT];
   logic [ADDR_W-1:0]       addr_chain [NEURON_COUNT];
   mask_type                mask_chain [NEURON_COUNT + 1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= BYTE_COUNT_W'(1);
         active_ff     <= ACTIVE_W'(8);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BYTE_COUNT: byte_count_ff <= csr_write_data;
            CSR_ACTIVE:     active_ff     <= csr_write_data[ACTIVE_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      if (byte_count_ff == '0) begin
         count_clamp = CNT_W'(1);
      end else if (CNT_W'(byte_count_ff) > CNT_W'(MAX_INPUT_BYTES)) begin
         count_clamp = CNT_W'(MAX_INPUT_BYTES);
      end else begin
         count_clamp = CNT_W'(byte_count_ff);
      end
   end

   assign active_clamp = (active_ff > ACTIVE_W'(NEURON_COUNT)) ?
                         ACTIVE_W'(NEURON_COUNT) : active_ff;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign seen_next = CNT_W'(bytes_seen_ff) + 1'b1;
   assign is_last   = (seen_next >= count_clamp);
   assign last_xfer = req_xfer && (req_op == OP_DATA) && is_last;

   assign sel_ok   = (ACTIVE_W'(req_neuron_sel) < ACTIVE_W'(NEURON_COUNT));
   assign pos_ok   = (CNT_W'(req_byte_pos) < CNT_W'(MAX_INPUT_BYTES));
   assign pos_wide = POS_W'(req_byte_pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
      end else if (req_xfer && req_op == OP_DATA) begin
         bytes_seen_ff <= is_last ? '0 : seen_next[ADDR_W-1:0];
      end
   end

   // token entering the first cell
   always_comb begin
      tok_chain[0].nsel         = req_neuron_sel;
      tok_chain[0].plane_high   = req_plane_high;
      tok_chain[0].plane_middle = req_plane_middle;
      tok_chain[0].plane_low    = req_plane_low;
      tok_chain[0].fire_level   = req_fire_level;
      tok_chain[0].data_byte    = req_data_byte;
      tok_chain[0].last         = is_last;
      tok_chain[0].kind         = OP_NONE;
      addr_chain[0]             = bytes_seen_ff;
      if (req_xfer) begin
         unique case (req_op)
            OP_WEIGHT: begin
               if (sel_ok && pos_ok) begin
                  tok_chain[0].kind = OP_WEIGHT;
               end
               addr_chain[0] = pos_wide[ADDR_W-1:0];
            end
            OP_THRESH: begin
               if (sel_ok) begin
                  tok_chain[0].kind = OP_THRESH;
               end
            end
            OP_DATA: tok_chain[0].kind = OP_DATA;
            default: tok_chain[0].kind = OP_NONE;
         endcase
      end
   end

   assign mask_chain[0] = '0;

   generate
      for (genvar i = 0; i < NEURON_COUNT; i++) begin : g_cell
         if (i < NEURON_COUNT - 1) begin : g_mid
            bnl_cell #(
               .MAX_INPUT_BYTES (MAX_INPUT_BYTES),
               .IDX             (i),
               .HAS_NEXT        (1'b1)
            ) u_cell (
               .clock          (clock),
               .reset          (reset),
               .active_neurons (active_clamp),
               .tok_in         (tok_chain[i]),
               .addr_in        (addr_chain[i]),
               .tok_out        (tok_chain[i+1]),
               .addr_out       (addr_chain[i+1]),
               .mask_in        (mask_chain[i]),
               .mask_out       (mask_chain[i+1])
            );
         end else begin : g_tail
            bnl_cell #(
               .MAX_INPUT_BYTES (MAX_INPUT_BYTES),
               .IDX             (i),
               .HAS_NEXT        (1'b0)
            ) u_cell (
               .clock          (clock),
               .reset          (reset),
               .active_neurons (active_clamp),
               .tok_in         (tok_chain[i]),
               .addr_in        (addr_chain[i]),
               .tok_out        (),
               .addr_out       (),
               .mask_in        (mask_chain[i]),
               .mask_out       (mask_chain[i+1])
            );
         end
      end
   endgenerate

   // results owed to the receiver, in the chain or in the queue
   always_comb begin
      pending_in = pending_ff;
      if (last_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_xfer && !last_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assign req_ready = (pending_ff < RSP_CNT_W'(RSP_DEPTH));

   bnl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mask_chain[NEURON_COUNT].valid),
      .push_data (mask_chain[NEURON_COUNT].bits),
      .pop       (rsp_xfer),
      .out_valid (rsp_valid),
      .out_data  (rsp_fired_mask)
   );

endmodule

// ===== rtl/bnl_cell.sv =====
// ----------------------------------------------------------------------------
// bnl_cell: one neuron of the chain
// Holds the neuron's weight planes, threshold and running sum. Each cycle
// it acts on the token from its left neighbor, passes it on when HAS_NEXT
// is set, and adds its fired bit to the mask that travels down the chain.
// ----------------------------------------------------------------------------
module bnl_cell
   import bnl_pkg::*;
#(
   parameter int MAX_INPUT_BYTES = DEF_MAX_INPUT_BYTES,
   parameter int IDX             = 0,
   parameter bit HAS_NEXT        = 1'b1,
   localparam int ADDR_W = (MAX_INPUT_BYTES > 1) ? $clog2(MAX_INPUT_BYTES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ACTIVE_W-1:0] active_neurons,
   input  token_type           tok_in,
   input  logic [ADDR_W-1:0]   addr_in,
   output token_type           tok_out,
   output logic [ADDR_W-1:0]   addr_out,
   input  mask_type            mask_in,
   output mask_type            mask_out
);

   logic [7:0] mem_h [MAX_INPUT_BYTES];
   logic [7:0] mem_m [MAX_INPUT_BYTES];
   logic [7:0] mem_l [MAX_INPUT_BYTES];

   logic signed [SUM_W-1:0] thr_ff;
   logic [7:0]              rd_h_ff;
   logic [7:0]              rd_m_ff;
   logic [7:0]              rd_l_ff;
   logic [7:0]              byte_a_ff;
   logic signed [SUM_W-1:0] thr_a_ff;
   logic                    data_a_ff;
   logic                    last_a_ff;
   logic                    act_a_ff;

   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] fin_ff;
   logic signed [SUM_W-1:0] thr_b_ff;
   logic                    last_b_ff;
   logic                    act_b_ff;

   mask_type                mask_ff;

   logic                    hit_token;
   logic                    cell_active;
   logic signed [7:0]       term;
   logic signed [SUM_W-1:0] acc;
   logic                    fired;

   assign hit_token   = (tok_in.nsel == 3'(IDX));
   assign cell_active = (ACTIVE_W'(IDX) < active_neurons);

   // stage a: weight memories, threshold and the read for a data byte
   always_ff @(posedge clock) begin
      if (tok_in.kind == OP_WEIGHT && hit_token) begin
         mem_h[addr_in] <= tok_in.plane_high;
         mem_m[addr_in] <= tok_in.plane_middle;
         mem_l[addr_in] <= tok_in.plane_low;
      end
      if (tok_in.kind == OP_THRESH && hit_token) begin
         thr_ff <= tok_in.fire_level;
      end
      rd_h_ff   <= mem_h[addr_in];
      rd_m_ff   <= mem_m[addr_in];
      rd_l_ff   <= mem_l[addr_in];
      byte_a_ff <= tok_in.data_byte;
      thr_a_ff  <= thr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_a_ff <= 1'b0;
         last_a_ff <= 1'b0;
         act_a_ff  <= 1'b0;
      end else begin
         data_a_ff <= (tok_in.kind == OP_DATA);
         last_a_ff <= (tok_in.kind == OP_DATA) && tok_in.last;
         act_a_ff  <= cell_active;
      end
   end

   // stage b: accumulate
   assign term = bnl_term(byte_a_ff, rd_h_ff, rd_m_ff, rd_l_ff);
   assign acc  = sum_ff + SUM_W'(term);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         last_b_ff <= 1'b0;
         act_b_ff  <= 1'b0;
      end else begin
         if (data_a_ff) begin
            if (last_a_ff) begin
               sum_ff <= '0;
            end else if (act_a_ff) begin
               sum_ff <= acc;
            end
         end
         last_b_ff <= last_a_ff;
         act_b_ff  <= act_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff   <= acc;
      thr_b_ff <= thr_a_ff;
   end

   // stage c: compare and merge into the mask from the left
   assign fired = act_b_ff && (fin_ff >= thr_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff.valid <= 1'b0;
      end else begin
         mask_ff.valid <= last_b_ff;
      end
      mask_ff.bits <= mask_in.bits | (MASK_W'(fired) << IDX);
   end

   assign mask_out = mask_ff;

   generate
      if (HAS_NEXT) begin : g_fwd
         token_type           tok_ff;
         logic [ADDR_W-1:0]   addr_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               tok_ff.kind <= OP_NONE;
            end else begin
               tok_ff.kind <= tok_in.kind;
            end
            tok_ff.nsel         <= tok_in.nsel;
            tok_ff.plane_high   <= tok_in.plane_high;
            tok_ff.plane_middle <= tok_in.plane_middle;
            tok_ff.plane_low    <= tok_in.plane_low;
            tok_ff.fire_level   <= tok_in.fire_level;
            tok_ff.data_byte    <= tok_in.data_byte;
            tok_ff.last         <= tok_in.last;
            addr_ff             <= addr_in;
         end
         assign tok_out  = tok_ff;
         assign addr_out = addr_ff;
      end else begin : g_end
         assign tok_out  = '0;
         assign addr_out = '0;
      end
   endgenerate

endmodule

// ===== rtl/bnl_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// bnl_rsp_queue: result queue
// Small register queue between the end of the neuron chain and the
// result channel; the chain never stalls, the queue absorbs the results.
// ----------------------------------------------------------------------------
module bnl_rsp_queue
   import bnl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [MASK_W-1:0] push_data,
   input  logic              pop,
   output logic              out_valid,
   output logic [MASK_W-1:0] out_data
);

   logic [MASK_W-1:0]    entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff;
   logic [RSP_CNT_W-1:0] count_in;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for binary_neuron_layer_xnor_popcount_unit
// Loads every weight and threshold, runs a short directed set of masks, then
// random phases under several register settings. A scoreboard class predicts
// each fired mask from the accepted items and checks the rsp side in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import bnl_pkg::*;

   localparam int MAX_BYTES    = DEF_MAX_INPUT_BYTES;
   localparam int NEURONS      = DEF_NEURON_COUNT;
   localparam int RANDOM_ITEMS = 680;
   localparam int DRAIN_CYCLES = NEURONS + 2 + 8;
   localparam int STALL_LIMIT  = 3000;

   typedef struct {
      logic [1:0]         op;
      logic [2:0]         nsel;
      logic [4:0]         pos;
      logic [7:0]         ph;
      logic [7:0]         pm;
      logic [7:0]         pl;
      logic signed [15:0] level;
      logic [7:0]         data;
   } layer_req_type;

   class fired_mask_board;
      logic [7:0]         plane_hi  [NEURONS*MAX_BYTES];
      logic [7:0]         plane_mid [NEURONS*MAX_BYTES];
      logic [7:0]         plane_lo  [NEURONS*MAX_BYTES];
      logic signed [15:0] level     [NEURONS];
      int                 sums      [NEURONS];
      int                 bytes_seen;
      logic [5:0]         count_reg;
      logic [3:0]         active_reg;
      logic [MASK_W-1:0]  owed_masks [$];
      int                 failures;

      function new();
         foreach (sums[n]) sums[n] = 0;
         bytes_seen = 0;
         count_reg  = 6'd1;
         active_reg = 4'd8;
         failures   = 0;
      endfunction

      function void set_reg(logic idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_BYTE_COUNT) count_reg = value[5:0];
         else active_reg = value[3:0];
      endfunction

      function int bytes_per_pass();
         if (count_reg == 0) return 1;
         if (count_reg > MAX_BYTES) return MAX_BYTES;
         return count_reg;
      endfunction

      // agreement score of one plane, -8..8
      function int plane_score(logic [7:0] d, logic [7:0] w);
         return 2 * $countones(~(d ^ w)) - 8;
      endfunction

      function void take_item(layer_req_type it);
         int addr;
         int act;
         logic [MASK_W-1:0] mask;
         case (it.op)
            OP_WEIGHT: begin
               addr = it.nsel * MAX_BYTES + it.pos;
               plane_hi[addr]  = it.ph;
               plane_mid[addr] = it.pm;
               plane_lo[addr]  = it.pl;
            end
            OP_THRESH: level[it.nsel] = it.level;
            OP_DATA: begin
               act = (active_reg > NEURONS) ? NEURONS : active_reg;
               if (bytes_seen < MAX_BYTES) begin
                  for (int n = 0; n < act; n++) begin
                     addr = n * MAX_BYTES + bytes_seen;
                     sums[n] += 4 * plane_score(it.data, plane_hi[addr])
                              + 2 * plane_score(it.data, plane_mid[addr])
                              + plane_score(it.data, plane_lo[addr]);
                  end
               end
               if (bytes_seen + 1 < bytes_per_pass()) begin
                  bytes_seen++;
               end else begin
                  mask = '0;
                  for (int n = 0; n < act; n++) begin
                     if (sums[n] >= level[n]) mask[n] = 1'b1;
                  end
                  owed_masks.push_back(mask);
                  foreach (sums[n]) sums[n] = 0;
                  bytes_seen = 0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_mask(logic [MASK_W-1:0] got);
         logic [MASK_W-1:0] want;
         if (owed_masks.size() == 0) begin
            failures++;
            $display("%0t: fired mask expected none, actual %h", $time, got);
            return;
         end
         want = owed_masks.pop_front();
         if (got !== want) begin
            failures++;
            $display("%0t: fired mask expected %h, actual %h", $time, want, got);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_op;
   logic [2:0]            req_neuron_sel;
   logic [4:0]            req_byte_pos;
   logic [7:0]            req_plane_high;
   logic [7:0]            req_plane_middle;
   logic [7:0]            req_plane_low;
   logic signed [15:0]    req_fire_level;
   logic [7:0]            req_data_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [MASK_W-1:0]     rsp_fired_mask;
   logic                  csr_write_enable;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   fired_mask_board layer;
   bit              calm;
   int              bytes_open;
   int              rsp_hold;
   int              idle_cycles;

   binary_neuron_layer_xnor_popcount_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_neuron_sel   (req_neuron_sel),
      .req_byte_pos     (req_byte_pos),
      .req_plane_high   (req_plane_high),
      .req_plane_middle (req_plane_middle),
      .req_plane_low    (req_plane_low),
      .req_fire_level   (req_fire_level),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fired_mask   (rsp_fired_mask),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // threshold near the spread of the sums, now and then a range extreme
   function automatic logic signed [15:0] pick_level(int pass_bytes);
      int span;
      span = 16 + 8 * pass_bytes;
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 2 * span) - span);
      endcase
   endfunction

   function automatic layer_req_type make_item(logic [1:0] op);
      layer_req_type it;
      it.op    = op;
      it.nsel  = 3'($urandom);
      it.pos   = 5'($urandom);
      it.ph    = 8'($urandom);
      it.pm    = 8'($urandom);
      it.pl    = 8'($urandom);
      it.level = 16'($urandom);
      it.data  = 8'($urandom);
      return it;
   endfunction

   // valid stays high across back-to-back transfers
   task automatic send_item(input layer_req_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= it.op;
      req_neuron_sel   <= it.nsel;
      req_byte_pos     <= it.pos;
      req_plane_high   <= it.ph;
      req_plane_middle <= it.pm;
      req_plane_low    <= it.pl;
      req_fire_level   <= it.level;
      req_data_byte    <= it.data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_weight(int n, int p, logic [7:0] h, logic [7:0] m, logic [7:0] l);
      layer_req_type it;
      it = make_item(OP_WEIGHT);
      it.nsel = 3'(n);
      it.pos  = 5'(p);
      it.ph   = h;
      it.pm   = m;
      it.pl   = l;
      send_item(it);
   endtask

   task automatic send_level(int n, logic signed [15:0] lvl);
      layer_req_type it;
      it = make_item(OP_THRESH);
      it.nsel  = 3'(n);
      it.level = lvl;
      send_item(it);
   endtask

   task automatic send_byte(logic [7:0] d);
      layer_req_type it;
      it = make_item(OP_DATA);
      it.data = d;
      send_item(it);
      bytes_open = (bytes_open + 1) % layer.bytes_per_pass();
   endtask

   // no inference or write left in the chain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (layer.owed_masks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_layer(logic [CSR_DATA_W-1:0] cnt, logic [CSR_DATA_W-1:0] act);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BYTE_COUNT;
      csr_write_data   <= cnt;
      @(posedge clock);
      csr_index        <= CSR_ACTIVE;
      csr_write_data   <= act;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      layer.set_reg(CSR_BYTE_COUNT, cnt);
      layer.set_reg(CSR_ACTIVE, act);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_hold = 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            rsp_hold = pick_gap();
            if (rsp_hold > 0) rsp_ready <= 1'b0;
         end
      end else begin
         rsp_hold = rsp_hold - 1;
         if (rsp_hold == 0) rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : transfer_monitor
      layer_req_type seen;
      if (!reset && req_valid && req_ready) begin
         seen.op    = req_op;
         seen.nsel  = req_neuron_sel;
         seen.pos   = req_byte_pos;
         seen.ph    = req_plane_high;
         seen.pm    = req_plane_middle;
         seen.pl    = req_plane_low;
         seen.level = req_fire_level;
         seen.data  = req_data_byte;
         layer.take_item(seen);
      end
      if (!reset && rsp_valid && rsp_ready) layer.check_mask(rsp_fired_mask);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase;
      int goal;
      int sent;
      int pick;
      logic [CSR_DATA_W-1:0] cnt_val;
      logic [CSR_DATA_W-1:0] act_val;

      layer            = new();
      calm             = 1'b0;
      bytes_open       = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_NONE;
      req_neuron_sel   = '0;
      req_byte_pos     = '0;
      req_plane_high   = '0;
      req_plane_middle = '0;
      req_plane_low    = '0;
      req_fire_level   = '0;
      req_data_byte    = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_BYTE_COUNT;
      csr_write_data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every store entry is written before any data byte reads it
      calm = $urandom_range(0, 1);
      for (int n = 0; n < NEURONS; n++) begin
         for (int p = 0; p < MAX_BYTES; p++) begin
            send_weight(n, p, 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
      for (int n = 0; n < NEURONS; n++) send_level(n, pick_level(1));

      // directed: plane extremes, exact threshold ties, threshold extremes
      calm = 1'b0;
      send_weight(7, 31, 8'hFF, 8'h00, 8'hAA);
      send_weight(0, 0, 8'h00, 8'hFF, 8'h55);
      send_weight(2, 0, 8'h3C, 8'h3C, 8'h3C);
      send_weight(3, 0, 8'hC3, 8'hC3, 8'hC3);
      send_level(0, 16'sh8000);
      send_level(1, 16'sh7FFF);
      send_level(2, 16'sd56);
      send_level(3, -16'sd56);
      send_item(make_item(OP_NONE));
      send_byte(8'h3C);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_level(2, 16'sd57);
      send_byte(8'h3C);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase % 10)
            0: begin cnt_val = 6'd1;  act_val = 6'd8;  end
            1: begin cnt_val = 6'd32; act_val = 6'd8;  end
            2: begin cnt_val = 6'd0;  act_val = 6'd15; end
            3: begin cnt_val = 6'd63; act_val = 6'd0;  end
            4: begin cnt_val = 6'd3;  act_val = 6'd5;  end
            5: begin cnt_val = 6'd33; act_val = 6'd9;  end
            9: begin cnt_val = 6'($urandom); act_val = 6'($urandom); end
            default: begin
               cnt_val = 6'($urandom_range(1, 6));
               act_val = 6'($urandom);
            end
         endcase
         wait_idle();
         program_layer(cnt_val, act_val);
         calm       = ($urandom_range(0, 3) == 0);
         bytes_open = 0;
         goal       = $urandom_range(40, 120);
         for (int k = 0; k < goal || bytes_open != 0; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
               send_byte(8'($urandom));
               sent++;
            end else if (pick < 86) begin
               send_weight($urandom_range(0, NEURONS - 1), $urandom_range(0, MAX_BYTES - 1),
                           8'($urandom), 8'($urandom), 8'($urandom));
               sent++;
            end else if (pick < 96) begin
               send_level($urandom_range(0, NEURONS - 1),
                          pick_level(layer.bytes_per_pass()));
               sent++;
            end else begin
               send_item(make_item(OP_NONE));
            end
         end
         phase++;
      end

      wait_idle();
      if (layer.failures == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bnl_pkg.sv
rtl/bnl_cell.sv
rtl/bnl_rsp_queue.sv
rtl/binary_neuron_layer_xnor_popcount_unit.sv
dv/tb_top.sv
